### src/odd_even_transposition_sorter_defines.svh
// Assertion macros for the sorter RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ODD_EVEN_TRANSPOSITION_SORTER_DEFINES_SVH
`define ODD_EVEN_TRANSPOSITION_SORTER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OETS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define OETS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/oets_pkg.sv
// Shared types and constants for the odd-even transposition sorter.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package oets_pkg;

    // Width of the value fields on the ports.
    localparam int FIELD_WIDTH = 32;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SORT,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // write the incoming value at the fill position
        logic sort;       // run one compare-swap phase
        logic phase_odd;  // phase parity: pairs start at odd positions
        logic shift;      // advance the row toward position zero
    } cmd_t;

endpackage

`default_nettype wire

### src/oets_ctrl.sv
// Controller state machine of the sorter: load, sort phases, emit.
// Depends on oets_pkg and odd_even_transposition_sorter_defines.svh.
`default_nettype none
`include "odd_even_transposition_sorter_defines.svh"

module oets_ctrl #(
    parameter int MAX_ELEMENTS = 64,
    parameter int CNT_W        = 7
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic          is_last,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic               is_last_res,
    output oets_pkg::cmd_t     cmd,
    output logic [CNT_W-1:0]   count
);
    import oets_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   phase_reg;
    logic [CNT_W-1:0]   phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
            phase_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        phase_next = phase_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    // drop values once the row is full
                    if (count_reg < CNT_W'(MAX_ELEMENTS))
                    begin
                        cmd.load   = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    if (is_last)
                    begin
                        state_next = ST_SORT;
                        phase_next = '0;
                    end
                end
            end
            ST_SORT:
            begin
                cmd.sort      = 1'b1;
                cmd.phase_odd = phase_reg[0];
                if (phase_reg == count_reg - 1'b1)
                begin
                    state_next = ST_EMIT;
                    phase_next = '0;
                end
                else
                begin
                    phase_next = phase_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.shift  = 1'b1;
                    count_next = count_reg - 1'b1;
                    if (count_reg == CNT_W'(1))
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    assign is_last_res = (count_reg == CNT_W'(1));
    assign count       = count_reg;

    `OETS_ASSERT_NOW(a_count_bound, clk, rst_n, 1'b1, count_reg <= CNT_W'(MAX_ELEMENTS), "element count above capacity")
    `OETS_ASSERT_NOW(a_nonempty_run, clk, rst_n, state_reg == ST_SORT || state_reg == ST_EMIT, count_reg != '0, "sort or emit with an empty row")
    `OETS_ASSERT_NOW(a_phase_bound, clk, rst_n, state_reg == ST_SORT, phase_reg < count_reg, "phase counter past element count")
    `OETS_ASSERT_NEXT(a_run_done, clk, rst_n, out_valid && out_ready && is_last_res, in_ready && count_reg == '0 && phase_reg == '0, "row not emptied after final beat")

endmodule

`default_nettype wire

### src/oets_datapath.sv
// Datapath of the sorter: row of element registers with compare-swap cells.
// Depends on oets_pkg for the command struct and port field width.
`default_nettype none

module oets_datapath #(
    parameter int MAX_ELEMENTS = 64,
    parameter int DATA_WIDTH   = 32,
    parameter int CNT_W        = 7
) (
    input  wire logic                               clk,
    input  wire oets_pkg::cmd_t                     cmd,
    input  wire logic [CNT_W-1:0]                   count,
    input  wire logic [oets_pkg::FIELD_WIDTH-1:0]   value,
    output logic [oets_pkg::FIELD_WIDTH-1:0]        sorted_value
);
    import oets_pkg::*;

    localparam int IDX_W = $clog2(MAX_ELEMENTS);

    logic [DATA_WIDTH-1:0] row_reg  [MAX_ELEMENTS];
    logic [DATA_WIDTH-1:0] row_next [MAX_ELEMENTS];
    logic [DATA_WIDTH-1:0] value_ext;

    // fit the port value to the element width; upper port bits are ignored if the element is narrower
    generate
        if (DATA_WIDTH > FIELD_WIDTH)
        begin : g_in_wide
            assign value_ext = {{(DATA_WIDTH-FIELD_WIDTH){1'b0}}, value};
            assign sorted_value = row_reg[0][FIELD_WIDTH-1:0];
        end
        else if (DATA_WIDTH == FIELD_WIDTH)
        begin : g_in_same
            assign value_ext = value;
            assign sorted_value = row_reg[0];
        end
        else
        begin : g_in_narrow
            assign value_ext = value[DATA_WIDTH-1:0];
            assign sorted_value = {{(FIELD_WIDTH-DATA_WIDTH){1'b0}}, row_reg[0]};
        end
    endgenerate

    always_comb
    begin
        row_next = row_reg;
        if (cmd.load)
        begin
            row_next[count[IDX_W-1:0]] = value_ext;
        end
        if (cmd.sort)
        begin
            // pairs within one phase are disjoint, so all cells of the phase swap at once
            for (int j = 0; j < MAX_ELEMENTS - 1; j++)
            begin
                if (((j % 2) == 1) == cmd.phase_odd && CNT_W'(j + 1) < count)
                begin
                    if ($signed(row_reg[j]) > $signed(row_reg[j+1]))
                    begin
                        row_next[j]   = row_reg[j+1];
                        row_next[j+1] = row_reg[j];
                    end
                end
            end
        end
        if (cmd.shift)
        begin
            for (int j = 0; j < MAX_ELEMENTS - 1; j++)
            begin
                row_next[j] = row_reg[j+1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_reg <= row_next;
    end

endmodule

`default_nettype wire

### src/odd_even_transposition_sorter.sv
// Top level of the odd-even transposition sorter.
// Depends on oets_pkg, oets_ctrl and oets_datapath.
//
//  Channel | Signals                                         | Direction
//  --------+-------------------------------------------------+----------
//  input   | in_valid, in_ready, value, is_last              | in
//  output  | out_valid, out_ready, sorted_value, is_last_res | out
//
// Loading accepts input beats while in_ready is high; beats past MAX_ELEMENTS are dropped.
// The beat marked last starts n sort phases over the n held values; each phase
// is one pass of the compare-swap cells across the row.
// Emission then gives one beat per cycle that out_ready is high, lowest first.
// in_ready is low from the last input beat until the final output beat.
// Reset clears the controller only; the element row holds no reset value.
`default_nettype none

module odd_even_transposition_sorter #(
    parameter int MAX_ELEMENTS = 64,
    parameter int DATA_WIDTH   = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [oets_pkg::FIELD_WIDTH-1:0]   value,
    input  wire logic                               is_last,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [oets_pkg::FIELD_WIDTH-1:0]        sorted_value,
    output logic                                    is_last_res
);
    import oets_pkg::*;

    // count must hold MAX_ELEMENTS itself
    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    cmd_t               cmd;
    logic [CNT_W-1:0]   count;

    // sequence load, sort phases and emission
    oets_ctrl #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .CNT_W        (CNT_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .is_last      (is_last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .is_last_res  (is_last_res),
        .cmd          (cmd),
        .count        (count)
    );

    // hold the row, swap pairs, advance toward the output
    oets_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .DATA_WIDTH   (DATA_WIDTH),
        .CNT_W        (CNT_W)
    ) u_datapath (
        .clk          (clk),
        .cmd          (cmd),
        .count        (count),
        .value        (value),
        .sorted_value (sorted_value)
    );

endmodule

`default_nettype wire

### tb/odd_even_transposition_sorter_tb.sv
// Self-checking testbench for the odd-even transposition sorter.
// Depends on oets_pkg and odd_even_transposition_sorter; predicts each sorted run
// internally and checks every output beat against it.

module tb;
    import oets_pkg::*;

    // Block configuration under test (the defaults of the top level).
    localparam int STORE_DEPTH = 64;
    localparam int ELEM_WIDTH  = 32;

    // Emission of a full row plus its sort phases bounds the quiet tail at the end.
    localparam int SETTLE_CYCLES = 2 * STORE_DEPTH + 16;
    // Stop offering random sets once this many beats have gone in overall.
    localparam int STIMULUS_STOP = 266;
    // Generous ceiling on the whole run, in clock cycles.
    localparam int LIMIT_CYCLES  = 200_000;

    localparam logic [FIELD_WIDTH-1:0] VALUE_MIN = {1'b1, {(FIELD_WIDTH - 1){1'b0}}};
    localparam logic [FIELD_WIDTH-1:0] VALUE_MAX = {1'b0, {(FIELD_WIDTH - 1){1'b1}}};

    typedef enum {
        READY_ALWAYS,
        READY_PATTERN,
        READY_RANDOM
    } ready_style_t;

    // One output beat as it should appear on the result channel.
    typedef struct packed {
        logic [FIELD_WIDTH-1:0] value;
        logic                   last;
    } sorted_beat_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_ready;
    logic [FIELD_WIDTH-1:0] value     = '0;
    logic                   is_last   = 1'b0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [FIELD_WIDTH-1:0] sorted_value;
    logic                   is_last_res;

    // Predictor state: values of the set being collected, and sorted beats
    // still owed by the block, oldest first.
    logic [ELEM_WIDTH-1:0]  held_values[$];
    sorted_beat_t           expected_beats[$];
    sorted_beat_t           next_expected;

    int                     mismatch_count  = 0;
    int                     elements_sent   = 0;

    // Sender pacing: bursts of random length separated by gaps up to gap_max.
    int                     burst_left      = 0;
    int                     gap_max         = 4;

    // Receiver pacing: a long hold-off overrides the current style.
    int                     hold_off_cycles = 0;
    ready_style_t           ready_style     = READY_RANDOM;
    logic [15:0]            ready_pattern   = 16'hFFFF;

    odd_even_transposition_sorter #(
        .MAX_ELEMENTS(STORE_DEPTH),
        .DATA_WIDTH  (ELEM_WIDTH)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .value       (value),
        .is_last     (is_last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sorted_value(sorted_value),
        .is_last_res (is_last_res)
    );

    // 8-unit clock: rising edges at 4, 12, 20, ...
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what, input logic [FIELD_WIDTH-1:0] got,
                                   input logic [FIELD_WIDTH-1:0] want);
        mismatch_count++;
        $display("mismatch at %0t: %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Run n phases of odd-even transposition over the collected set, exactly
    // as the hardware row does, then owe one beat per value, lowest first,
    // with the greatest one marked. Empty the set for the next one.
    function automatic void predict_sorted_run();
        logic [ELEM_WIDTH-1:0] swap;
        int                    n;
        sorted_beat_t          beat;
        n = held_values.size();
        for (int p = 0; p < n; p++)
            for (int j = p % 2; j + 1 < n; j += 2)
                if ($signed(held_values[j]) > $signed(held_values[j + 1]))
                begin
                    swap               = held_values[j];
                    held_values[j]     = held_values[j + 1];
                    held_values[j + 1] = swap;
                end
        for (int k = 0; k < n; k++)
        begin
            beat.value = FIELD_WIDTH'(held_values[k]);
            beat.last  = (k == n - 1) ? 1'b1 : 1'b0;
            expected_beats.push_back(beat);
        end
        held_values.delete();
    endfunction

    // Offer one input beat and hold it until accepted. Between bursts, drop
    // valid for a random gap first. On acceptance, feed the predictor: store
    // the value if there is room, and sort when the beat carries the mark.
    task automatic send_element(input logic [FIELD_WIDTH-1:0] v, input logic mark);
        int gap;
        @(negedge clk);
        if (gap_max > 0 && burst_left == 0)
        begin
            gap = $urandom_range(1, gap_max);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 12);
        end
        in_valid <= 1'b1;
        value    <= v;
        is_last  <= mark;
        do
            @(posedge clk);
        while (!in_ready);
        if (burst_left > 0)
            burst_left--;
        elements_sent++;
        if (held_values.size() < STORE_DEPTH)
            held_values.push_back(v[ELEM_WIDTH-1:0]);
        if (mark)
            predict_sorted_run();
    endtask

    // Mix of extremes, small values that collide, and full-range values.
    function automatic logic [FIELD_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return VALUE_MIN;
            1:       return VALUE_MAX;
            2, 3:    return FIELD_WIDTH'(int'($urandom_range(0, 8)) - 4);
            default: return FIELD_WIDTH'($urandom());
        endcase
    endfunction

    // Send a set of n random values, the last one marked.
    task automatic send_set(input int n);
        for (int i = 0; i < n; i++)
            send_element(pick_value(), (i == n - 1) ? 1'b1 : 1'b0);
    endtask

    // Drop valid and hold off until the block has delivered every owed beat.
    task automatic pause_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
    endtask

    // A set of one value comes back as is, marked last; try both extremes.
    task automatic test_single_element();
        send_element(VALUE_MIN, 1'b1);
        send_element(VALUE_MAX, 1'b1);
    endtask

    // Signed extremes, zero, minus one and duplicates in one set.
    task automatic test_extreme_values();
        send_element(VALUE_MAX, 1'b0);
        send_element(VALUE_MIN, 1'b0);
        send_element('0, 1'b0);
        send_element('1, 1'b0);
        send_element(FIELD_WIDTH'(1), 1'b0);
        send_element(VALUE_MIN, 1'b0);
        send_element(VALUE_MAX, 1'b1);
    endtask

    // Strictly descending input: every pair swaps in every phase.
    task automatic test_descending_run();
        send_element(FIELD_WIDTH'(100), 1'b0);
        send_element(FIELD_WIDTH'(50), 1'b0);
        send_element('0, 1'b0);
        send_element(FIELD_WIDTH'(-50), 1'b0);
        send_element(FIELD_WIDTH'(-100), 1'b0);
        send_element(VALUE_MIN, 1'b1);
    endtask

    // Fill the row exactly with the mark on the final slot; then overrun it:
    // unmarked beats past capacity are dropped, and a marked beat past
    // capacity is dropped too but still starts the sort of the full row.
    task automatic test_store_full();
        send_set(STORE_DEPTH);
        for (int i = 0; i < STORE_DEPTH + 2; i++)
            send_element(pick_value(), 1'b0);
        send_element(pick_value(), 1'b1);
    endtask

    // Hold the receiver off for a long stretch while the sender keeps
    // offering the next set back to back, so the input stalls behind the
    // blocked emission.
    task automatic test_output_hold_off();
        gap_max = 0;
        @(posedge clk);
        hold_off_cycles = 300;
        send_set(24);
        send_set(8);
        gap_max = 4;
    endtask

    // Let each set drain completely before the next one starts.
    task automatic test_pause_between_sets();
        repeat (6)
        begin
            send_set($urandom_range(1, 10));
            pause_until_drained();
        end
    endtask

    // Random sets, mostly small, with pacing of both sides sometimes changing between sets.
    task automatic test_random_sets();
        int pick;
        int n;
        while (elements_sent < STIMULUS_STOP)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 15)
                n = $urandom_range(1, 8);
            else if (pick < 19)
                n = $urandom_range(9, 24);
            else
                n = $urandom_range(25, 48);
            if ($urandom_range(0, 3) == 0)
            begin
                gap_max     = $urandom_range(0, 8);
                ready_style = ready_style_t'($urandom_range(0, 2));
                ready_pattern = 16'($urandom()) | 16'h0001;
            end
            send_set(n);
        end
    endtask

    // Receiver: advance the hold-off count, else follow the current style.
    always @(negedge clk)
    begin
        if (hold_off_cycles > 0)
        begin
            hold_off_cycles--;
            out_ready <= 1'b0;
        end
        else
            case (ready_style)
                READY_ALWAYS:
                    out_ready <= 1'b1;
                READY_PATTERN:
                begin
                    out_ready     <= ready_pattern[0];
                    ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
                end
                default:
                    out_ready <= ($urandom_range(0, 3) != 0);
            endcase
    end

    // Checker: compare every accepted output beat with the oldest owed one.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_beats.size() == 0)
                report_mismatch("output beat with nothing owed", sorted_value, '0);
            else
            begin
                next_expected = expected_beats.pop_front();
                if (sorted_value !== next_expected.value)
                    report_mismatch("sorted_value", sorted_value, next_expected.value);
                if (is_last_res !== next_expected.last)
                    report_mismatch("is_last_res", FIELD_WIDTH'(is_last_res),
                                    FIELD_WIDTH'(next_expected.last));
            end
        end
    end

    // Test sequence: reset once, directed sets, then the random part.
    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_single_element();
        test_extreme_values();
        test_descending_run();
        test_store_full();
        test_output_hold_off();
        test_pause_between_sets();
        test_random_sets();

        // Drain, then watch a quiet tail for stray beats.
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: a hung handshake ends the run here.
    initial
    begin
        #(LIMIT_CYCLES * 8);
        $display("FAILURE");
        $finish;
    end

endmodule
